[src/berlekamp_massey_mod_prime_top_macros.svh]
// Assertion macros used by the checker file of the block.
`ifndef BERLEKAMP_MASSEY_MOD_PRIME_TOP_MACROS_SVH
`define BERLEKAMP_MASSEY_MOD_PRIME_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define BMP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk and quiet during reset.
`define BMP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/bmp_pkg.sv]
// Types and constants of the prime field Berlekamp-Massey block.
package bmp_pkg;

  localparam int VAL_W = 30;
  localparam int IDX_W = 6;
  localparam int LEN_W = 7;
  localparam int MAX_LEN_DEF = 64;

  localparam logic [VAL_W-1:0] PRIME = 30'd1000000007;
  localparam logic [VAL_W-1:0] INV_EXP = 30'd1000000005;

  typedef struct packed {
    logic [VAL_W-1:0] sequence_value;
    logic             last_element;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] coefficient;
    logic [IDX_W-1:0] coefficient_index;
    logic [LEN_W-1:0] recurrence_length;
    logic             last_result;
  } out_t;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] res;
  } mul_rsp_t;

endpackage

[src/bmp_mulmod.sv]
// Bit-serial modular multiplier: one bit of the multiplier per cycle.
module bmp_mulmod
  import bmp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int CNT_W = $clog2(VAL_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [VAL_W-1:0] acc_r;
  logic [VAL_W-1:0] a_r;
  logic [VAL_W-1:0] b_r;
  logic [VAL_W-1:0] acc_nxt;
  logic [VAL_W:0]   dbl;
  logic [VAL_W-1:0] dbl_red;
  logic [VAL_W:0]   sum;

  // Horner step: acc = 2*acc + bit*a, both reduced by one conditional subtract.
  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, PRIME}) ? VAL_W'(dbl - {1'b0, PRIME}) : dbl[VAL_W-1:0];
    sum     = {1'b0, dbl_red} + (b_r[VAL_W-1] ? {1'b0, a_r} : '0);
    acc_nxt = (sum >= {1'b0, PRIME}) ? VAL_W'(sum - {1'b0, PRIME}) : sum[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(VAL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= '0;
      a_r   <= req.a;
      b_r   <= req.b;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[VAL_W-2:0], 1'b0};
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = acc_r;

endmodule

[src/berlekamp_massey_mod_prime_top.sv]
// Top level: sequence store, polynomial stores and the Berlekamp-Massey sequencer.
//
// Elements are written with start while busy is low. An element with last_element set
// starts the run, and busy stays high until the last coefficient has been strobed on
// out_valid, each read in S_OADR and strobed from S_OEMIT; results cannot be held off
// by the receiver. A run first clears the polynomial stores, then per element forms
// the discrepancy with one multiply for each coefficient of the dot product, and at
// each nonzero discrepancy once the recurrence is nonempty 46 multiplies for the
// Fermat inverse (30 squarings, 15 products for the set exponent bits and the final
// product) plus one multiply per polynomial entry updated. All products go through
// one bit-serial modular multiplier.
module berlekamp_massey_mod_prime_top
  import bmp_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CLR   = 5'd1;
  localparam logic [4:0] S_IBEG  = 5'd2;
  localparam logic [4:0] S_XLD   = 5'd3;
  localparam logic [4:0] S_DADR  = 5'd4;
  localparam logic [4:0] S_DMUL  = 5'd5;
  localparam logic [4:0] S_DWAIT = 5'd6;
  localparam logic [4:0] S_DCHK  = 5'd7;
  localparam logic [4:0] S_INV   = 5'd8;
  localparam logic [4:0] S_IWR   = 5'd9;
  localparam logic [4:0] S_ISQ   = 5'd10;
  localparam logic [4:0] S_IWB   = 5'd11;
  localparam logic [4:0] S_KWAIT = 5'd12;
  localparam logic [4:0] S_UADR  = 5'd13;
  localparam logic [4:0] S_UMUL  = 5'd14;
  localparam logic [4:0] S_UWAIT = 5'd15;
  localparam logic [4:0] S_OADR  = 5'd16;
  localparam logic [4:0] S_OEMIT = 5'd17;

  logic [4:0]       state_r, state_nxt;
  logic [LW-1:0]    n_r, n_nxt;
  logic [LW-1:0]    i_r, i_nxt;
  logic [LW-1:0]    j_r, j_nxt;
  logic [LW-1:0]    curlen_r, curlen_nxt;
  logic [LW-1:0]    prevlen_r, prevlen_nxt;
  logic [LW-1:0]    lastfail_r, lastfail_nxt;
  logic [LW-1:0]    gap_r, gap_nxt;
  logic [LW-1:0]    newlen_r, newlen_nxt;
  logic             copy_r, copy_nxt;
  logic [VAL_W-1:0] lastdisc_r, lastdisc_nxt;
  logic [VAL_W-1:0] t_r, t_nxt;
  logic [VAL_W-1:0] x_r, x_nxt;
  logic [VAL_W-1:0] d_r, d_nxt;
  logic [VAL_W-1:0] k_r, k_nxt;
  logic [VAL_W-1:0] e_r, e_nxt;
  logic [VAL_W-1:0] r_r, r_nxt;
  logic [VAL_W-1:0] b_r, b_nxt;
  logic [VAL_W-1:0] cq_r, cq_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  logic [VAL_W-1:0] seq_mem [MAX_LEN];
  logic [VAL_W-1:0] cur_mem [MAX_LEN];
  logic [VAL_W-1:0] prev_mem [MAX_LEN];
  logic [VAL_W-1:0] seq_q, cur_q, prev_q;
  logic [AW-1:0]    seq_ra, cur_ra, prev_ra;
  logic             seq_we, cur_we, prev_we;
  logic [AW-1:0]    seq_wa, pol_wa;
  logic [VAL_W-1:0] seq_wd, cur_wd, prev_wd;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  bmp_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  logic [VAL_W-1:0] vred;
  logic [VAL_W:0]   tsum;
  logic [LW:0]      span, nl, jg;
  logic [VAL_W:0]   s1;
  logic [VAL_W-1:0] s1r;
  logic [VAL_W-1:0] pv;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    curlen_nxt    = curlen_r;
    prevlen_nxt   = prevlen_r;
    lastfail_nxt  = lastfail_r;
    gap_nxt       = gap_r;
    newlen_nxt    = newlen_r;
    copy_nxt      = copy_r;
    lastdisc_nxt  = lastdisc_r;
    t_nxt         = t_r;
    x_nxt         = x_r;
    d_nxt         = d_r;
    k_nxt         = k_r;
    e_nxt         = e_r;
    r_nxt         = r_r;
    b_nxt         = b_r;
    cq_nxt        = cq_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mreq          = '0;
    seq_ra        = '0;
    cur_ra        = j_r[AW-1:0];
    prev_ra       = '0;
    seq_we        = 1'b0;
    cur_we        = 1'b0;
    prev_we       = 1'b0;
    seq_wa        = n_r[AW-1:0];
    pol_wa        = j_r[AW-1:0];
    cur_wd        = '0;
    prev_wd       = '0;

    vred   = (in_data.sequence_value >= PRIME) ? in_data.sequence_value - PRIME
                                               : in_data.sequence_value;
    seq_wd = vred;
    tsum   = {1'b0, t_r} + {1'b0, mrsp.res};
    span   = {1'b0, gap_r} + {1'b0, prevlen_r};
    nl     = '0;
    jg     = {1'b0, j_r} - {1'b0, gap_r};
    s1     = {1'b0, cq_r} + (({1'b0, j_r} + 1'b1 == {1'b0, gap_r}) ? {1'b0, k_r} : '0);
    s1r    = (s1 >= {1'b0, PRIME}) ? VAL_W'(s1 - {1'b0, PRIME}) : s1[VAL_W-1:0];
    pv     = ((j_r >= gap_r) && (jg < {1'b0, prevlen_r})) ? prev_q : '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (n_r < LW'(MAX_LEN)) begin
            seq_we = 1'b1;
            n_nxt  = n_r + 1'b1;
          end
          if (in_data.last_element) begin
            j_nxt        = '0;
            i_nxt        = '0;
            curlen_nxt   = '0;
            prevlen_nxt  = '0;
            lastfail_nxt = '0;
            lastdisc_nxt = '0;
            state_nxt    = S_CLR;
          end
        end
      end
      S_CLR: begin
        cur_we  = 1'b1;
        prev_we = 1'b1;
        j_nxt   = j_r + 1'b1;
        if (j_r == LW'(MAX_LEN - 1)) state_nxt = S_IBEG;
      end
      S_IBEG: begin
        seq_ra = i_r[AW-1:0];
        t_nxt  = '0;
        j_nxt  = '0;
        if (i_r >= n_r) begin
          state_nxt = S_OADR;
        end else begin
          state_nxt = S_XLD;
        end
      end
      S_XLD: begin
        x_nxt     = seq_q;
        state_nxt = S_DADR;
      end
      S_DADR: begin
        seq_ra = AW'(i_r - j_r - 1'b1);
        if ((j_r < curlen_r) && (j_r < i_r)) state_nxt = S_DMUL;
        else state_nxt = S_DCHK;
      end
      S_DMUL: begin
        mreq      = '{start: 1'b1, a: seq_q, b: cur_q};
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (mrsp.done) begin
          t_nxt     = (tsum >= {1'b0, PRIME}) ? VAL_W'(tsum - {1'b0, PRIME})
                                              : tsum[VAL_W-1:0];
          j_nxt     = j_r + 1'b1;
          state_nxt = S_DADR;
        end
      end
      S_DCHK: begin
        if (t_r == x_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_IBEG;
        end else begin
          d_nxt = (t_r >= x_r) ? t_r - x_r : VAL_W'({1'b0, t_r} + {1'b0, PRIME} - {1'b0, x_r});
          if (curlen_r == '0) begin
            curlen_nxt   = i_r + 1'b1;
            lastfail_nxt = i_r;
            lastdisc_nxt = d_nxt;
            i_nxt        = i_r + 1'b1;
            state_nxt    = S_IBEG;
          end else begin
            e_nxt     = INV_EXP;
            r_nxt     = VAL_W'(1);
            b_nxt     = lastdisc_r;
            state_nxt = S_INV;
          end
        end
      end
      S_INV: begin
        if (e_r == '0) begin
          mreq      = '{start: 1'b1, a: d_r, b: r_r};
          state_nxt = S_KWAIT;
        end else if (e_r[0]) begin
          mreq      = '{start: 1'b1, a: r_r, b: b_r};
          state_nxt = S_IWR;
        end else begin
          mreq      = '{start: 1'b1, a: b_r, b: b_r};
          state_nxt = S_IWB;
        end
      end
      S_IWR: begin
        if (mrsp.done) begin
          r_nxt     = mrsp.res;
          state_nxt = S_ISQ;
        end
      end
      S_ISQ: begin
        mreq      = '{start: 1'b1, a: b_r, b: b_r};
        state_nxt = S_IWB;
      end
      S_IWB: begin
        if (mrsp.done) begin
          b_nxt     = mrsp.res;
          e_nxt     = e_r >> 1;
          state_nxt = S_INV;
        end
      end
      S_KWAIT: begin
        if (mrsp.done) begin
          k_nxt      = mrsp.res;
          gap_nxt    = i_r - lastfail_r;
          span       = {1'b0, gap_nxt} + {1'b0, prevlen_r};
          nl         = (span < {1'b0, curlen_r}) ? {1'b0, curlen_r} : span;
          if (nl > (LW + 1)'(MAX_LEN)) nl = (LW + 1)'(MAX_LEN);
          newlen_nxt = nl[LW-1:0];
          copy_nxt   = (span >= {1'b0, curlen_r});
          j_nxt      = nl[LW-1:0] - 1'b1;
          state_nxt  = S_UADR;
        end
      end
      S_UADR: begin
        prev_ra   = jg[AW-1:0];
        state_nxt = S_UMUL;
      end
      S_UMUL: begin
        cq_nxt    = cur_q;
        mreq      = '{start: 1'b1, a: pv, b: k_r};
        state_nxt = S_UWAIT;
      end
      S_UWAIT: begin
        if (mrsp.done) begin
          // Entries go from the top down, so the old previous polynomial is read
          // below the index being overwritten.
          cur_we  = 1'b1;
          cur_wd  = (s1r >= mrsp.res) ? s1r - mrsp.res
                                      : VAL_W'({1'b0, s1r} + {1'b0, PRIME} - {1'b0, mrsp.res});
          prev_we = copy_r;
          prev_wd = cq_r;
          if (j_r == '0) begin
            if (copy_r) begin
              prevlen_nxt  = curlen_r;
              lastfail_nxt = i_r;
              lastdisc_nxt = d_r;
            end
            curlen_nxt = newlen_r;
            i_nxt      = i_r + 1'b1;
            state_nxt  = S_IBEG;
          end else begin
            j_nxt     = j_r - 1'b1;
            state_nxt = S_UADR;
          end
        end
      end
      S_OADR: begin
        state_nxt = S_OEMIT;
      end
      S_OEMIT: begin
        out_valid_nxt = 1'b1;
        if (curlen_r == '0) begin
          out_nxt   = '{coefficient: '0, coefficient_index: '0,
                        recurrence_length: '0, last_result: 1'b1};
          n_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          out_nxt.coefficient       = cur_q;
          out_nxt.coefficient_index = IDX_W'(j_r);
          out_nxt.recurrence_length = LEN_W'(curlen_r);
          out_nxt.last_result       = (j_r + 1'b1 == curlen_r);
          j_nxt                     = j_r + 1'b1;
          if (j_r + 1'b1 == curlen_r) begin
            n_nxt     = '0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_OADR;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    curlen_r   <= curlen_nxt;
    prevlen_r  <= prevlen_nxt;
    lastfail_r <= lastfail_nxt;
    gap_r      <= gap_nxt;
    newlen_r   <= newlen_nxt;
    copy_r     <= copy_nxt;
    lastdisc_r <= lastdisc_nxt;
    t_r        <= t_nxt;
    x_r        <= x_nxt;
    d_r        <= d_nxt;
    k_r        <= k_nxt;
    e_r        <= e_nxt;
    r_r        <= r_nxt;
    b_r        <= b_nxt;
    cq_r       <= cq_nxt;
    out_r      <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (seq_we) seq_mem[seq_wa] <= seq_wd;
    if (cur_we) cur_mem[pol_wa] <= cur_wd;
    if (prev_we) prev_mem[pol_wa] <= prev_wd;
    seq_q  <= seq_mem[seq_ra];
    cur_q  <= cur_mem[cur_ra];
    prev_q <= prev_mem[prev_ra];
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[src/bmp_checker.sv]
// Port-level checker for the Berlekamp-Massey block, bound to the top level.
`include "berlekamp_massey_mod_prime_top_macros.svh"

module bmp_checker
  import bmp_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input in_t  in_data,
  input logic out_valid,
  input out_t out_data
);

  `BMP_ASSERT_NEXT(a_elem_stays_idle, start && !busy && !in_data.last_element, !busy)
  `BMP_ASSERT_NEXT(a_last_starts_run, start && !busy && in_data.last_element, busy)
  `BMP_ASSERT_NEXT(a_run_continues, out_valid && !out_data.last_result, busy)
  `BMP_ASSERT_IMPL(a_empty_is_single, out_valid && out_data.recurrence_length == '0, out_data.last_result)

endmodule

bind berlekamp_massey_mod_prime_top bmp_checker u_bmp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
